FILE: hdl/ssa_pkg.sv
package ssa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int ADDR_BITS = 32;

  // Stack index width and the width of counters that must also hold MAX_SLOTS.
  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int COUNT_W = $clog2(MAX_SLOTS + 1);

  localparam int SIZE_W  = 17;
  localparam int SCNT_W  = 11;
  // Region size in bytes: up to MAX_SLOTS * (2^SIZE_W - 1).
  localparam int TOTAL_W = COUNT_W + SIZE_W;
  // The bump offset may step one slot past the region end.
  localparam int BUMP_W  = TOTAL_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 2'd2;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] FILL_EMPTY   = 2'd0;
  localparam logic [1:0] FILL_PARTIAL = 2'd1;
  localparam logic [1:0] FILL_FULL    = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] region_base;
    logic [SIZE_W-1:0]    slot_bytes;
    logic [COUNT_W-1:0]   eff_count;
    logic [TOTAL_W-1:0]   total_bytes;
  } cfg_t;

endpackage

FILE: hdl/ssa_free_stack.sv
module ssa_free_stack
  import ssa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [ADDR_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [ADDR_BITS-1:0] wr_data
);

  logic [ADDR_BITS-1:0] mem [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/ssa_cfg.sv
module ssa_cfg
  import ssa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [ADDR_BITS-1:0] region_base;
  logic [SIZE_W-1:0]    slot_bytes;
  logic [SCNT_W-1:0]    slot_count;
  logic [COUNT_W-1:0]   eff_count;
  logic [TOTAL_W-1:0]   total_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      slot_bytes  <= SIZE_W'(8);
      slot_count  <= SCNT_W'(MAX_SLOTS);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REGION_BASE: region_base <= cfg_data[ADDR_BITS-1:0];
        REG_SLOT_BYTES:  slot_bytes  <= cfg_data[SIZE_W-1:0];
        REG_SLOT_COUNT:  slot_count  <= cfg_data[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slot_count > SCNT_W'(MAX_SLOTS)) begin
      eff_count = COUNT_W'(MAX_SLOTS);
    end else begin
      eff_count = COUNT_W'(slot_count);
    end
  end

  // Region size is registered; an item reads it in the cycle after acceptance.
  always_ff @(posedge clk) begin
    total_bytes <= TOTAL_W'(eff_count) * TOTAL_W'(slot_bytes);
  end

  assign cfg.region_base = region_base;
  assign cfg.slot_bytes  = slot_bytes;
  assign cfg.eff_count   = eff_count;
  assign cfg.total_bytes = total_bytes;

endmodule

FILE: hdl/slab_slot_allocator.sv
// Slab slot allocator with a LIFO free stack held in a 1024-entry synchronous RAM.
// An accepted item moves the block to the execute state, whose results are registered;
// the result strobe done is high for exactly one cycle.
// The block takes no new item while busy, that is while in the execute state.
// Reset (synchronous, rst high) empties the stack and the bump offset, clears the
// used count and status, and loads the registers with base 0, 8-byte slots, 1024 slots.
module slab_slot_allocator
  import ssa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation,
  input  logic [ADDR_BITS-1:0]  address,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [ADDR_BITS-1:0]  result_address,
  output logic                  ok,
  output logic                  in_range,
  output logic [1:0]            fill_state
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  cfg_t cfg;

  logic                 state;
  logic [1:0]           op_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [COUNT_W-1:0]   stack_depth;
  logic [COUNT_W-1:0]   stack_depth_next;
  logic [BUMP_W-1:0]    bump_offset;
  logic [BUMP_W-1:0]    bump_offset_next;
  logic [COUNT_W-1:0]   used_slots;
  logic [COUNT_W-1:0]   used_slots_next;
  logic [1:0]           status_reg;
  logic [1:0]           status_reg_next;

  logic                 accept;
  logic [ADDR_BITS-1:0] top_data;
  logic                 push;
  logic [ADDR_BITS-1:0] offset;
  logic                 addr_hit;
  logic [ADDR_BITS-1:0] res_c;
  logic                 ok_c;
  logic                 inr_c;

  ssa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state == ST_EXEC);

  // The top of the stack is fetched while the item is accepted, whatever
  // the operation; only an allocate uses it.
  ssa_free_stack u_stack (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (IDX_W'(stack_depth - COUNT_W'(1))),
    .rd_data (top_data),
    .wr_en   (push),
    .wr_addr (stack_depth[IDX_W-1:0]),
    .wr_data (addr_q)
  );

  assign offset   = addr_q - cfg.region_base;
  assign addr_hit = offset < ADDR_BITS'(cfg.total_bytes);

  always_comb begin
    stack_depth_next = stack_depth;
    bump_offset_next = bump_offset;
    used_slots_next  = used_slots;
    status_reg_next  = status_reg;
    res_c            = '0;
    ok_c             = 1'b0;
    inr_c            = 1'b0;
    push             = 1'b0;
    if (state == ST_EXEC) begin
      unique case (op_q)
        OP_ALLOC: begin
          if (status_reg != FILL_FULL) begin
            if (stack_depth != '0) begin
              stack_depth_next = stack_depth - COUNT_W'(1);
              res_c            = top_data;
              ok_c             = 1'b1;
            end else if (bump_offset < BUMP_W'(cfg.total_bytes)) begin
              res_c            = cfg.region_base + ADDR_BITS'(bump_offset);
              bump_offset_next = bump_offset + BUMP_W'(cfg.slot_bytes);
              ok_c             = 1'b1;
            end
            if (ok_c) begin
              used_slots_next = used_slots + COUNT_W'(1);
              status_reg_next = (used_slots_next >= cfg.eff_count) ? FILL_FULL : FILL_PARTIAL;
            end
          end
          inr_c = ok_c;
        end
        OP_FREE: begin
          inr_c = addr_hit;
          if (addr_hit && (used_slots != '0) && (stack_depth < COUNT_W'(MAX_SLOTS))) begin
            push             = 1'b1;
            stack_depth_next = stack_depth + COUNT_W'(1);
            used_slots_next  = used_slots - COUNT_W'(1);
            status_reg_next  = (used_slots_next == '0) ? FILL_EMPTY : FILL_PARTIAL;
            ok_c             = 1'b1;
          end
        end
        OP_QUERY: begin
          inr_c = addr_hit;
          ok_c  = addr_hit;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      stack_depth <= '0;
      bump_offset <= '0;
      used_slots  <= '0;
      status_reg  <= FILL_EMPTY;
    end else begin
      done        <= (state == ST_EXEC);
      stack_depth <= stack_depth_next;
      bump_offset <= bump_offset_next;
      used_slots  <= used_slots_next;
      status_reg  <= status_reg_next;
      unique case (state)
        ST_IDLE: if (start) state <= ST_EXEC;
        ST_EXEC: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      addr_q <= address;
    end
    if (state == ST_EXEC) begin
      result_address <= res_c;
      ok             <= ok_c;
      in_range       <= inr_c;
      fill_state     <= status_reg_next;
    end
  end

endmodule

FILE: hdl/ssa_checker.sv
module ssa_checker
  import ssa_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [ADDR_BITS-1:0] result_address,
  input logic                 ok,
  input logic                 in_range,
  input logic [1:0]           fill_state
);

  // An accepted item raises busy, and the result strobe follows busy with busy dropped.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("result strobe missing after busy cycle");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in work");

  // A refused item never carries an address, and a granted one is always in the region.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> result_address == '0)
    else $error("refused item carries an address");

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    done && ok |-> in_range && (fill_state != 2'd3))
    else $error("granted item outside the region or bad fill state");

endmodule

bind slab_slot_allocator ssa_checker u_ssa_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .result_address (result_address),
  .ok             (ok),
  .in_range       (in_range),
  .fill_state     (fill_state)
);

FILE: tb/tb_slab_slot_allocator.sv
`timescale 1ns / 1ps

module tb_slab_slot_allocator;
  import ssa_pkg::*;

  // Operation code that the block does not define.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [ADDR_BITS-1:0] addr;
    logic                 ok;
    logic                 in_range;
    logic [1:0]           fill;
  } slot_result_t;

  // Tracks the allocator state, predicts the result of each accepted item and
  // checks the block's results against those predictions in order.
  class allocator_book;
    bit [ADDR_BITS-1:0] base;
    bit [SIZE_W-1:0]    bytes_per_slot;
    bit [SCNT_W-1:0]    slots;
    bit [ADDR_BITS-1:0] stack [MAX_SLOTS];
    bit [COUNT_W-1:0]   depth;
    bit [BUMP_W-1:0]    bump;
    bit [COUNT_W-1:0]   used;
    bit [1:0]           fill;
    slot_result_t       pending_results[$];
    bit [ADDR_BITS-1:0] granted_addrs[$];
    int                 errors;

    function new();
      base = '0;
      bytes_per_slot = SIZE_W'(8);
      slots = SCNT_W'(1024);
      depth = '0;
      bump = '0;
      used = '0;
      fill = FILL_EMPTY;
      errors = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_REGION_BASE: base = data[ADDR_BITS-1:0];
        REG_SLOT_BYTES:  bytes_per_slot = data[SIZE_W-1:0];
        REG_SLOT_COUNT:  slots = data[SCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [COUNT_W-1:0] usable_slots();
      return (slots > MAX_SLOTS) ? COUNT_W'(MAX_SLOTS) : COUNT_W'(slots);
    endfunction

    function bit [TOTAL_W-1:0] region_bytes();
      return TOTAL_W'(usable_slots()) * TOTAL_W'(bytes_per_slot);
    endfunction

    function bit in_region(bit [ADDR_BITS-1:0] a);
      bit [ADDR_BITS-1:0] off;
      off = a - base;
      return off < region_bytes();
    endfunction

    function void take_command(bit [1:0] op, bit [ADDR_BITS-1:0] a);
      slot_result_t r;
      int k;
      r.addr = '0;
      r.ok = 1'b0;
      r.in_range = 1'b0;
      case (op)
        OP_ALLOC: begin
          if (fill != FILL_FULL) begin
            if (depth > 0 && depth <= MAX_SLOTS) begin
              depth = depth - 1'b1;
              r.addr = stack[depth];
              r.ok = 1'b1;
            end else if (bump < region_bytes()) begin
              r.addr = base + ADDR_BITS'(bump);
              bump = bump + bytes_per_slot;
              r.ok = 1'b1;
            end
            if (r.ok) begin
              used = used + 1'b1;
              fill = (used >= usable_slots()) ? FILL_FULL : FILL_PARTIAL;
              granted_addrs.push_back(r.addr);
            end
          end
          r.in_range = r.ok;
        end
        OP_FREE: begin
          r.in_range = in_region(a);
          if (r.in_range && used > 0 && depth < MAX_SLOTS) begin
            stack[depth] = a;
            depth = depth + 1'b1;
            used = used - 1'b1;
            fill = (used == 0) ? FILL_EMPTY : FILL_PARTIAL;
            r.ok = 1'b1;
            k = 0;
            while (k < granted_addrs.size()) begin
              if (granted_addrs[k] == a) begin
                granted_addrs.delete(k);
                break;
              end
              k++;
            end
          end
        end
        OP_QUERY: begin
          r.in_range = in_region(a);
          r.ok = r.in_range;
        end
        default: ;
      endcase
      r.fill = fill;
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [ADDR_BITS-1:0] want, logic [ADDR_BITS-1:0] got);
      errors++;
      $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    task match_result(logic [ADDR_BITS-1:0] addr, logic ok_o, logic inr_o, logic [1:0] fill_o);
      slot_result_t e;
      if (pending_results.size() == 0) begin
        report("unexpected result", '0, addr);
        return;
      end
      e = pending_results.pop_front();
      if (addr !== e.addr) report("result_address", e.addr, addr);
      if (ok_o !== e.ok) report("ok", e.ok, ok_o);
      if (inr_o !== e.in_range) report("in_range", e.in_range, inr_o);
      if (fill_o !== e.fill) report("fill_state", e.fill, fill_o);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            operation;
  logic [ADDR_BITS-1:0]  address;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  done;
  logic [ADDR_BITS-1:0]  result_address;
  logic                  ok;
  logic                  in_range;
  logic [1:0]            fill_state;

  allocator_book sb = new();

  slab_slot_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .address        (address),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .result_address (result_address),
    .ok             (ok),
    .in_range       (in_range),
    .fill_state     (fill_state)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.match_result(result_address, ok, in_range, fill_state);
  end

  task automatic send_item(input logic [1:0] op, input logic [ADDR_BITS-1:0] a);
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    address <= a;
    do @(posedge clk); while (busy);
    sb.take_command(op, a);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drops start, then waits for every predicted result and lets the block sit idle.
  task automatic wait_results();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_results.size() != 0) begin
      sb.report("missing results", sb.pending_results.size(), '0);
      sb.pending_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // Must only be called with the block idle. Upper size and count data bits carry junk.
  task automatic set_region(input logic [31:0] b, input logic [16:0] sz, input logic [10:0] cnt);
    logic [CFG_IDX_W-1:0]  regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs[0] = REG_REGION_BASE;
    regs[1] = REG_SLOT_BYTES;
    regs[2] = REG_SLOT_COUNT;
    vals[0] = b;
    vals[1] = {15'($urandom), sz};
    vals[2] = {21'($urandom), cnt};
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.granted_addrs.delete();
  endtask

  task automatic release_all(input int idle_pct);
    int n;
    n = sb.granted_addrs.size();
    repeat (n) begin
      if (sb.granted_addrs.size() > 0) send_item(OP_FREE, sb.granted_addrs[0]);
      if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 8));
    end
  endtask

  // Mostly allocate and free of granted slots, with queries and stray operation codes mixed in.
  task automatic run_mix(input int count, input int idle_pct);
    int r;
    logic [1:0] op;
    logic [ADDR_BITS-1:0] a;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        op = OP_ALLOC;
        a = $urandom;
      end else if (r < 80) begin
        op = OP_FREE;
        if (sb.granted_addrs.size() > 0 && $urandom_range(0, 4) != 0)
          a = sb.granted_addrs[$urandom_range(0, sb.granted_addrs.size() - 1)];
        else
          a = sb.base + $urandom_range(0, sb.region_bytes() + 1);
      end else if (r < 90) begin
        op = OP_QUERY;
        if ($urandom_range(0, 1) == 1) a = sb.base + $urandom_range(0, sb.region_bytes() + 1);
        else a = $urandom;
      end else begin
        op = ($urandom_range(0, 1) == 1) ? OP_UNUSED : OP_FREE;
        a = $urandom;
      end
      send_item(op, a);
      if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [31:0] b;
    logic [16:0] sz;
    logic [10:0] cnt;
    int pick;
    rst = 1'b1;
    start = 1'b0;
    operation = OP_ALLOC;
    address = '0;
    cfg_write = 1'b0;
    cfg_index = REG_REGION_BASE;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: 1024 slots of 8 bytes from address zero.
    send_item(OP_QUERY, 32'd8191);
    send_item(OP_QUERY, 32'd8192);
    wait_results();

    // A three-slot region that wraps past the top of the address space.
    set_region(32'hFFFF_FFF8, 17'd4, 11'd3);
    send_item(OP_QUERY, 32'hFFFF_FFF8);
    send_item(OP_QUERY, 32'h0000_0003);
    send_item(OP_QUERY, 32'h0000_0004);
    pause_sender(3);
    send_item(OP_QUERY, 32'hFFFF_FFF7);
    send_item(OP_FREE, 32'hFFFF_FFF8);
    send_item(OP_ALLOC, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'h0);
    pause_sender(1);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_FREE, 32'h0000_0000);
    send_item(OP_FREE, 32'h0000_0004);
    send_item(OP_FREE, 32'h0000_0001);
    send_item(OP_FREE, 32'h0000_0001);
    send_item(OP_FREE, 32'hFFFF_FFFC);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_FREE, 32'h0000_0000);
    send_item(OP_ALLOC, 32'h0);
    wait_results();

    // A larger count with the bump offset already past the region end.
    set_region(32'hFFFF_FFF8, 17'd1, 11'd7);
    send_item(OP_FREE, 32'hFFFF_FFF9);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    wait_results();

    // Zero-byte slots make an empty region.
    set_region(32'h0, 17'd0, 11'd5);
    send_item(OP_QUERY, 32'h0);
    send_item(OP_ALLOC, 32'h0);
    wait_results();

    // Largest slots and a count above the cap: take a few hundred slots, then free
    // them all, which leaves that many entries on the free stack.
    set_region($urandom, 17'h1FFFF, 11'h7FF);
    repeat (200) begin
      send_item(OP_ALLOC, $urandom);
      if ($urandom_range(0, 99) < 10) pause_sender($urandom_range(1, 8));
    end
    send_item(OP_QUERY, sb.base + sb.region_bytes() - 1);
    send_item(OP_QUERY, sb.base + sb.region_bytes());
    release_all(10);
    send_item(OP_FREE, sb.base);
    run_mix(60, 20);

    for (int p = 0; p < 12; p++) begin
      release_all(20);
      wait_results();
      if (p == 0) begin
        b = 32'h0;
        sz = 17'd1;
        cnt = 11'd1;
      end else if (p == 1) begin
        b = 32'hFFFF_FFFF;
        sz = 17'h1FFFF;
        cnt = 11'h7FF;
      end else begin
        pick = $urandom_range(0, 9);
        b = (pick < 2) ? 32'hFFFF_FFFF - $urandom_range(0, 64) : $urandom;
        pick = $urandom_range(0, 9);
        case (pick)
          0: sz = 17'd0;
          1: sz = 17'h1FFFF;
          2: sz = 17'($urandom);
          default: sz = 17'($urandom_range(1, 64));
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
          0: cnt = 11'd0;
          1: cnt = 11'h7FF;
          2: cnt = 11'd1024;
          3: cnt = 11'($urandom);
          default: cnt = 11'($urandom_range(1, 12));
        endcase
      end
      set_region(b, sz, cnt);
      run_mix(90, (p == 11) ? 0 : $urandom_range(0, 60));
    end

    wait_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
